// File: sv/deadline_job_sequencer_macros.svh
// Assertion macros for the deadline job sequencer.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef DEADLINE_JOB_SEQUENCER_MACROS_SVH
`define DEADLINE_JOB_SEQUENCER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DJS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DJS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/djs_pkg.sv
// Shared types, codes and helpers for the deadline job sequencer.
// No dependencies; imported by every module of the block.
package djs_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int DLC_W = 9;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_OFFER = 2'd1;
    localparam logic [1:0] OP_DUMP  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] K_CLEAR  = 2'd0;
    localparam logic [1:0] K_OFFER  = 2'd1;
    localparam logic [1:0] K_DUMP   = 2'd2;
    localparam logic [1:0] K_STATUS = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  job_id;
        logic [7:0]  job_deadline;
        logic [15:0] job_profit;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  entry_id;
        logic [4:0]  entry_count;
        logic [31:0] total_profit;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [7:0]  dl;
        logic [15:0] profit;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic             dumping;
        logic [CNT_W-1:0] count;
    } t_back_stat;

    function automatic logic [4:0] f_cnt5(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[4:0];
    endfunction

endpackage

// File: sv/deadline_job_sequencer.sv
// Top level of the deadline job sequencer: front queue plus schedule back end.
// Depends on djs_pkg, djs_front, djs_back and deadline_job_sequencer_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// An offer goes through the back end as a slot compare, then a placement check
// and commit, whether it is kept or turned away as infeasible; clear, status,
// offers to a full schedule and offers with deadline zero are answered straight
// from idle; a dump sends one result per schedule entry through the single output register.
// Reset (synchronous, active low) empties the queue, the schedule count and the
// profit total; slot contents stay undefined and are never read before written.
// A two-entry command queue lets input accept while the back end or output stalls.
`include "deadline_job_sequencer_macros.svh"

module deadline_job_sequencer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  djs_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output djs_pkg::t_out_item o_out_item
);
    import djs_pkg::*;

    t_q_head    head;
    logic       pop;
    t_back_stat stat;

    // Accept and classify incoming transactions; queue them for the back end.
    djs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Execute commands against the schedule and drive results.
    djs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_stat      (stat)
    );

    // Schedule never grows past its slot count.
    `DJS_ASSERT_ALWAYS(a_count_bound, stat.count <= CNT_W'(SLOTS), "schedule count overflow")

    // A pending non-final result can only come from a dump still in progress.
    `DJS_ASSERT_IMPL(a_nonlast_dump,
        o_out_valid && !o_out_item.last, stat.dumping,
        "non-final result outside dump")

    // An accepted offer is a single final result with no entry id.
    `DJS_ASSERT_IMPL(a_accept_shape,
        o_out_valid && o_out_item.accepted,
        o_out_item.last && (o_out_item.entry_id == 8'd0),
        "malformed accept result")

endmodule

// File: sv/djs_front.sv
// Front end: accepts input transactions, classifies them into commands
// and holds them in a two-entry queue. Depends on djs_pkg.
module djs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  djs_pkg::t_in_item i_in_item,
    output djs_pkg::t_q_head  o_head,
    input  logic              i_pop
);
    import djs_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       push;

    // Fold offers with deadline zero into a status command: never feasible.
    always_comb begin
        cls.id     = i_in_item.job_id;
        cls.dl     = i_in_item.job_deadline;
        cls.profit = i_in_item.job_profit;
        case (i_in_item.op)
            OP_CLEAR: cls.kind = K_CLEAR;
            OP_OFFER: cls.kind = (i_in_item.job_deadline == 8'd0) ? K_STATUS : K_OFFER;
            OP_DUMP:  cls.kind = K_DUMP;
            default:  cls.kind = K_STATUS;
        endcase
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready;
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

endmodule

// File: sv/djs_back.sv
// Back end: keeps the schedule, places offers, runs clears and dumps,
// and drives the output register. Depends on djs_pkg.
module djs_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  djs_pkg::t_q_head    i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output djs_pkg::t_out_item  o_out_item,
    output djs_pkg::t_back_stat o_stat
);
    import djs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PLACE = 2'd1;
    localparam logic [1:0] ST_DUMP  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [7:0]       r_ids [SLOTS];
    logic [7:0]       n_ids [SLOTS];
    logic [7:0]       r_dls [SLOTS];
    logic [7:0]       n_dls [SLOTS];
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_sum, n_sum;
    logic [SLOTS-1:0] r_ge, n_ge;
    t_cmd             r_job, n_job;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             out_free;
    logic [SLOTS-1:0] ge, live, ins, mv, ge_prev, mv_prev;
    logic             fit;
    logic [32:0]      sum33;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = (r_state == ST_IDLE) && i_head.valid && out_free;

    // Entries at or below the new deadline form a prefix of the sorted list.
    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            live[p] = (CNT_W'(p) < r_count);
            ge[p]   = live[p] && (i_head.cmd.dl >= r_dls[p]);
        end
    end

    // Insert point is the first slot past the prefix; later entries shift up.
    assign ge_prev = {r_ge[SLOTS-2:0], 1'b1};
    assign ins     = ge_prev & ~r_ge;
    assign mv      = live & ~r_ge;
    assign mv_prev = {mv[SLOTS-2:0], 1'b0};

    always_comb begin
        fit = 1'b1;
        for (int p = 0; p < SLOTS; p++) begin
            if (ins[p] && (DLC_W'(r_job.dl) < DLC_W'(p + 1))) begin
                fit = 1'b0;
            end
            if (mv[p] && (DLC_W'(r_dls[p]) < DLC_W'(p + 2))) begin
                fit = 1'b0;
            end
        end
    end

    assign sum33 = {1'b0, r_sum} + 33'(r_job.profit);

    always_comb begin
        n_state     = r_state;
        n_ids       = r_ids;
        n_dls       = r_dls;
        n_count     = r_count;
        n_sum       = r_sum;
        n_ge        = r_ge;
        n_job       = r_job;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_head.cmd.kind)
                        K_CLEAR: begin
                            n_count     = '0;
                            n_sum       = '0;
                            n_out_valid = 1'b1;
                            n_out       = '{accepted: 1'b0, entry_id: 8'd0,
                                            entry_count: 5'd0, total_profit: 32'd0,
                                            last: 1'b1};
                        end
                        K_OFFER: begin
                            if (r_count == CNT_W'(SLOTS)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{accepted: 1'b0, entry_id: 8'd0,
                                                entry_count: f_cnt5(r_count),
                                                total_profit: r_sum, last: 1'b1};
                            end else begin
                                n_ge    = ge;
                                n_job   = i_head.cmd;
                                n_state = ST_PLACE;
                            end
                        end
                        K_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = '{accepted: 1'b0, entry_id: 8'd0,
                                                entry_count: 5'd0,
                                                total_profit: r_sum, last: 1'b1};
                            end else begin
                                n_idx   = '0;
                                n_state = ST_DUMP;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = '{accepted: 1'b0, entry_id: 8'd0,
                                            entry_count: f_cnt5(r_count),
                                            total_profit: r_sum, last: 1'b1};
                        end
                    endcase
                end
            end
            ST_PLACE: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (fit) begin
                        for (int p = 0; p < SLOTS; p++) begin
                            if (ins[p]) begin
                                n_ids[p] = r_job.id;
                                n_dls[p] = r_job.dl;
                            end else if (mv_prev[p]) begin
                                n_ids[p] = r_ids[(p == 0) ? 0 : p - 1];
                                n_dls[p] = r_dls[(p == 0) ? 0 : p - 1];
                            end
                        end
                        n_count = r_count + CNT_W'(1);
                        n_sum   = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                    end
                    n_out = '{accepted: fit, entry_id: 8'd0,
                              entry_count: f_cnt5(n_count),
                              total_profit: n_sum, last: 1'b1};
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{accepted: 1'b0, entry_id: r_ids[r_idx],
                                    entry_count: f_cnt5(r_count),
                                    total_profit: r_sum,
                                    last: (CNT_W'(r_idx) + CNT_W'(1) == r_count)};
                    n_idx       = r_idx + IDX_W'(1);
                    if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ids <= n_ids;
        r_dls <= n_dls;
        r_ge  <= n_ge;
        r_job <= n_job;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;
    assign o_stat.dumping = (r_state == ST_DUMP);
    assign o_stat.count   = r_count;

endmodule
